@@ rtl/vecrot_pkg.sv @@
`timescale 1ns / 1ps
// shared types, constants and tables for the axis rotation pipeline
// no dependencies; used by every module of the block
package vecrot_pkg;

    // numeric setup
    localparam int CORDIC_STAGES = 24;
    localparam int FRAC_BITS     = 16;

    // field and datapath widths
    localparam int VEC_W    = 32;
    localparam int ANGLE_W  = 31;
    localparam int ANG_W    = 32;               // angle after sign extension
    localparam int XY_W     = 34;               // cordic x/y, q2.30 with headroom
    localparam int COEF_W   = FRAC_BITS + 2;    // cos/sin in [-1, +1]
    localparam int PROD_W   = VEC_W + COEF_W;
    localparam int SUM_W    = PROD_W + 2;
    localparam int S_DATA_W = ((VEC_W * 3 + ANGLE_W + 7) / 8) * 8;
    localparam int M_DATA_W = VEC_W * 3;

    // angle constants, q3.28
    localparam logic signed [ANG_W-1:0] PI_Q28      = 32'sd843314857;
    localparam logic signed [ANG_W-1:0] HALF_PI_Q28 = 32'sd421657428;
    localparam logic signed [ANG_W-1:0] TWO_PI_Q28  = 32'sd1686629713;

    // gain-corrected cordic start value, q2.30
    localparam longint KINF_Q30   = 64'sd652032874;
    localparam longint K_INIT_Q30 = (CORDIC_STAGES < 16) ?
        KINF_Q30 + (((KINF_Q30 * 2) / 3) >>> (2 * CORDIC_STAGES)) : KINF_Q30;

    // saturation bounds
    localparam logic signed [VEC_W-1:0] VEC_MAX = 32'sh7fffffff;
    localparam logic signed [VEC_W-1:0] VEC_MIN = 32'sh80000000;

    // rotation axis codes
    typedef enum logic [1:0] {
        AXIS_X    = 2'd0,
        AXIS_Y    = 2'd1,
        AXIS_Z    = 2'd2,
        AXIS_NONE = 2'd3
    } axis_t;

    // request fields that ride along the angle pipeline
    typedef struct packed {
        axis_t                     axis;
        logic signed [VEC_W-1:0]   vx;
        logic signed [VEC_W-1:0]   vy;
        logic signed [VEC_W-1:0]   vz;
    } side_t;

    // round(atan(2^-i) * 2^28)
    function automatic logic signed [ANG_W-1:0] atan_q28(input int unsigned idx);
        logic signed [ANG_W-1:0] v;
        case (idx)
            0:       v = 32'sd210828714;
            1:       v = 32'sd124459457;
            2:       v = 32'sd65760959;
            3:       v = 32'sd33381290;
            4:       v = 32'sd16755422;
            5:       v = 32'sd8385879;
            6:       v = 32'sd4193963;
            7:       v = 32'sd2097109;
            8:       v = 32'sd1048571;
            9:       v = 32'sd524287;
            10:      v = 32'sd262144;
            11:      v = 32'sd131072;
            12:      v = 32'sd65536;
            13:      v = 32'sd32768;
            14:      v = 32'sd16384;
            15:      v = 32'sd8192;
            16:      v = 32'sd4096;
            17:      v = 32'sd2048;
            18:      v = 32'sd1024;
            19:      v = 32'sd512;
            20:      v = 32'sd256;
            21:      v = 32'sd128;
            22:      v = 32'sd64;
            23:      v = 32'sd32;
            24:      v = 32'sd16;
            25:      v = 32'sd8;
            26:      v = 32'sd4;
            27:      v = 32'sd2;
            28:      v = 32'sd1;
            default: v = 32'sd0;
        endcase
        return v;
    endfunction

endpackage

@@ rtl/vector_axis_rotation_top.sv @@
`timescale 1ns / 1ps
// top level of the axis rotation block: stream ports and pipeline control
// depends on vecrot_pkg, vecrot_prep, vecrot_cordic, vecrot_mix
//
// Rotates a Q16.16 vector about the X, Y or Z axis by a Q3.28 angle in
// radians; axis code 3 passes the vector through. Fully pipelined: one
// request is taken every clock while the output is not stalled. Each
// request passes two angle reduction stages, one register stage per
// CORDIC iteration, then coefficient, multiply and round/saturate
// stages. The last stage is the output register. The whole pipeline
// moves together: it advances whenever the output holds nothing or is
// being taken, so a stalled result holds every stage and s_tready falls
// in the same cycle. m_tuser flags any clamped component.
module vector_axis_rotation_top (
    input  logic                                  aclk,
    input  logic                                  aresetn,
    input  logic                                  s_tvalid,
    output logic                                  s_tready,
    // vec_x[31:0], vec_y[63:32], vec_z[95:64], angle[126:96], zero pad
    input  logic [vecrot_pkg::S_DATA_W-1:0]       s_tdata,
    // axis[1:0]
    input  logic [1:0]                            s_tuser,
    output logic                                  m_tvalid,
    input  logic                                  m_tready,
    // out_x[31:0], out_y[63:32], out_z[95:64]
    output logic [vecrot_pkg::M_DATA_W-1:0]       m_tdata,
    // saturated[0]
    output logic                                  m_tuser
);
    import vecrot_pkg::*;

    logic                    adv;
    side_t                   in_side;
    logic signed [ANGLE_W-1:0] in_angle;

    logic                    prep_vld;
    side_t                   prep_side;
    logic signed [ANG_W-1:0] prep_z;
    logic                    prep_neg;

    logic                    cor_vld;
    side_t                   cor_side;
    logic                    cor_neg;
    logic signed [XY_W-1:0]  cor_cos;
    logic signed [XY_W-1:0]  cor_sin;

    logic signed [VEC_W-1:0] res_x;
    logic signed [VEC_W-1:0] res_y;
    logic signed [VEC_W-1:0] res_z;
    logic                    res_sat;

    // pipeline moves when the output register is free or being drained
    assign adv      = !m_tvalid || m_tready;
    assign s_tready = adv;

    // unpack the request
    assign in_side.axis = axis_t'(s_tuser);
    assign in_side.vx   = s_tdata[VEC_W-1:0];
    assign in_side.vy   = s_tdata[2*VEC_W-1:VEC_W];
    assign in_side.vz   = s_tdata[3*VEC_W-1:2*VEC_W];
    assign in_angle     = s_tdata[3*VEC_W+ANGLE_W-1:3*VEC_W];

    vecrot_prep u_prep (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .adv      (adv),
        .in_vld   (s_tvalid),
        .in_side  (in_side),
        .in_angle (in_angle),
        .out_vld  (prep_vld),
        .out_side (prep_side),
        .out_z    (prep_z),
        .out_neg  (prep_neg)
    );

    vecrot_cordic u_cordic (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .adv      (adv),
        .in_vld   (prep_vld),
        .in_side  (prep_side),
        .in_neg   (prep_neg),
        .in_z     (prep_z),
        .out_vld  (cor_vld),
        .out_side (cor_side),
        .out_neg  (cor_neg),
        .out_cos  (cor_cos),
        .out_sin  (cor_sin)
    );

    vecrot_mix u_mix (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .adv      (adv),
        .in_vld   (cor_vld),
        .in_side  (cor_side),
        .in_neg   (cor_neg),
        .in_cos   (cor_cos),
        .in_sin   (cor_sin),
        .out_vld  (m_tvalid),
        .out_x    (res_x),
        .out_y    (res_y),
        .out_z    (res_z),
        .out_sat  (res_sat)
    );

    // pack the result
    assign m_tdata = {res_z, res_y, res_x};
    assign m_tuser = res_sat;

    // a saturation flag always comes with a clamped component
    a_sat_clamped: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_tvalid && m_tuser) |->
            (res_x == VEC_MAX || res_x == VEC_MIN ||
             res_y == VEC_MAX || res_y == VEC_MIN ||
             res_z == VEC_MAX || res_z == VEC_MIN))
        else $error("saturation flag without a clamped component");

endmodule

@@ rtl/vecrot_prep.sv @@
`timescale 1ns / 1ps
// angle range reduction: two register stages ahead of the cordic
// depends on vecrot_pkg
module vecrot_prep (
    input  logic                                aclk,
    input  logic                                aresetn,
    input  logic                                adv,
    input  logic                                in_vld,
    input  vecrot_pkg::side_t                   in_side,
    input  logic signed [vecrot_pkg::ANGLE_W-1:0] in_angle,
    output logic                                out_vld,
    output vecrot_pkg::side_t                   out_side,
    output logic signed [vecrot_pkg::ANG_W-1:0] out_z,
    output logic                                out_neg
);
    import vecrot_pkg::*;

    logic                    wrap_vld_reg;
    side_t                   wrap_side_reg;
    logic signed [ANG_W-1:0] wrap_ang_reg;
    logic signed [ANG_W-1:0] wrap_ang_next;
    logic signed [ANG_W-1:0] ang_ext;

    logic                    fold_vld_reg;
    side_t                   fold_side_reg;
    logic signed [ANG_W-1:0] fold_ang_reg;
    logic signed [ANG_W-1:0] fold_ang_next;
    logic                    fold_neg_reg;
    logic                    fold_neg_next;

    // bring the angle into [-pi, pi]
    always_comb begin
        ang_ext = {in_angle[ANGLE_W-1], in_angle};
        if (ang_ext > PI_Q28) begin
            wrap_ang_next = ang_ext - TWO_PI_Q28;
        end else if (ang_ext < -PI_Q28) begin
            wrap_ang_next = ang_ext + TWO_PI_Q28;
        end else begin
            wrap_ang_next = ang_ext;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wrap_vld_reg <= 1'b0;
        end else if (adv) begin
            wrap_vld_reg <= in_vld;
        end
    end

    always_ff @(posedge aclk) begin
        if (adv) begin
            wrap_side_reg <= in_side;
            wrap_ang_reg  <= wrap_ang_next;
        end
    end

    // fold into [-pi/2, pi/2], remember to negate sin and cos
    always_comb begin
        if (wrap_ang_reg > HALF_PI_Q28) begin
            fold_ang_next = wrap_ang_reg - PI_Q28;
            fold_neg_next = 1'b1;
        end else if (wrap_ang_reg < -HALF_PI_Q28) begin
            fold_ang_next = wrap_ang_reg + PI_Q28;
            fold_neg_next = 1'b1;
        end else begin
            fold_ang_next = wrap_ang_reg;
            fold_neg_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            fold_vld_reg <= 1'b0;
        end else if (adv) begin
            fold_vld_reg <= wrap_vld_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (adv) begin
            fold_side_reg <= wrap_side_reg;
            fold_ang_reg  <= fold_ang_next;
            fold_neg_reg  <= fold_neg_next;
        end
    end

    assign out_vld  = fold_vld_reg;
    assign out_side = fold_side_reg;
    assign out_z    = fold_ang_reg;
    assign out_neg  = fold_neg_reg;

endmodule

@@ rtl/vecrot_cordic.sv @@
`timescale 1ns / 1ps
// rotation-mode cordic, one iteration per register stage
// depends on vecrot_pkg
module vecrot_cordic (
    input  logic                                aclk,
    input  logic                                aresetn,
    input  logic                                adv,
    input  logic                                in_vld,
    input  vecrot_pkg::side_t                   in_side,
    input  logic                                in_neg,
    input  logic signed [vecrot_pkg::ANG_W-1:0] in_z,
    output logic                                out_vld,
    output vecrot_pkg::side_t                   out_side,
    output logic                                out_neg,
    output logic signed [vecrot_pkg::XY_W-1:0]  out_cos,
    output logic signed [vecrot_pkg::XY_W-1:0]  out_sin
);
    import vecrot_pkg::*;

    localparam logic signed [XY_W-1:0] X_START = XY_W'(K_INIT_Q30);
    localparam logic signed [ANG_W-1:0] Z_BOUND =
        2 * atan_q28(CORDIC_STAGES - 1) + ANG_W'(2 * CORDIC_STAGES);

    logic                    vld_reg  [CORDIC_STAGES];
    side_t                   side_reg [CORDIC_STAGES];
    logic                    neg_reg  [CORDIC_STAGES];
    logic signed [XY_W-1:0]  x_reg    [CORDIC_STAGES];
    logic signed [XY_W-1:0]  y_reg    [CORDIC_STAGES];
    logic signed [ANG_W-1:0] z_reg    [CORDIC_STAGES];

    for (genvar i = 0; i < CORDIC_STAGES; i++) begin : g_iter
        logic                    vld_in;
        side_t                   side_in;
        logic                    neg_in;
        logic signed [XY_W-1:0]  x_in;
        logic signed [XY_W-1:0]  y_in;
        logic signed [ANG_W-1:0] z_in;
        logic signed [XY_W-1:0]  x_next;
        logic signed [XY_W-1:0]  y_next;
        logic signed [ANG_W-1:0] z_next;

        // stage input: pipeline head or previous iteration
        if (i == 0) begin : g_head
            assign vld_in  = in_vld;
            assign side_in = in_side;
            assign neg_in  = in_neg;
            assign x_in    = X_START;
            assign y_in    = '0;
            assign z_in    = in_z;
        end else begin : g_body
            assign vld_in  = vld_reg[i-1];
            assign side_in = side_reg[i-1];
            assign neg_in  = neg_reg[i-1];
            assign x_in    = x_reg[i-1];
            assign y_in    = y_reg[i-1];
            assign z_in    = z_reg[i-1];
        end

        // micro-rotation toward zero residual angle
        always_comb begin
            if (z_in >= 0) begin
                x_next = x_in - (y_in >>> i);
                y_next = y_in + (x_in >>> i);
                z_next = z_in - atan_q28(i);
            end else begin
                x_next = x_in + (y_in >>> i);
                y_next = y_in - (x_in >>> i);
                z_next = z_in + atan_q28(i);
            end
        end

        always_ff @(posedge aclk) begin
            if (!aresetn) begin
                vld_reg[i] <= 1'b0;
            end else if (adv) begin
                vld_reg[i] <= vld_in;
            end
        end

        always_ff @(posedge aclk) begin
            if (adv) begin
                side_reg[i] <= side_in;
                neg_reg[i]  <= neg_in;
                x_reg[i]    <= x_next;
                y_reg[i]    <= y_next;
                z_reg[i]    <= z_next;
            end
        end
    end

    assign out_vld  = vld_reg[CORDIC_STAGES-1];
    assign out_side = side_reg[CORDIC_STAGES-1];
    assign out_neg  = neg_reg[CORDIC_STAGES-1];
    assign out_cos  = x_reg[CORDIC_STAGES-1];
    assign out_sin  = y_reg[CORDIC_STAGES-1];

    // residual angle has converged by the last iteration
    a_z_converged: assert property (@(posedge aclk) disable iff (!aresetn)
        out_vld |-> (z_reg[CORDIC_STAGES-1] <= Z_BOUND &&
                     z_reg[CORDIC_STAGES-1] >= -Z_BOUND))
        else $error("cordic residual angle did not converge");

    // vector stays within the q2.30 headroom
    a_xy_range: assert property (@(posedge aclk) disable iff (!aresetn)
        out_vld |-> (out_cos[XY_W-1] == out_cos[XY_W-2] &&
                     out_sin[XY_W-1] == out_sin[XY_W-2]))
        else $error("cordic vector outgrew its headroom");

endmodule

@@ rtl/vecrot_mix.sv @@
`timescale 1ns / 1ps
// coefficient rounding, products and saturated sums for the rotated pair
// depends on vecrot_pkg
module vecrot_mix (
    input  logic                                aclk,
    input  logic                                aresetn,
    input  logic                                adv,
    input  logic                                in_vld,
    input  vecrot_pkg::side_t                   in_side,
    input  logic                                in_neg,
    input  logic signed [vecrot_pkg::XY_W-1:0]  in_cos,
    input  logic signed [vecrot_pkg::XY_W-1:0]  in_sin,
    output logic                                out_vld,
    output logic signed [vecrot_pkg::VEC_W-1:0] out_x,
    output logic signed [vecrot_pkg::VEC_W-1:0] out_y,
    output logic signed [vecrot_pkg::VEC_W-1:0] out_z,
    output logic                                out_sat
);
    import vecrot_pkg::*;

    localparam logic signed [XY_W-1:0]   COEF_RND = XY_W'(1) << (29 - FRAC_BITS);
    localparam logic signed [XY_W-1:0]   ONE_XY   = XY_W'(1) << FRAC_BITS;
    localparam logic signed [COEF_W-1:0] ONE_COEF = COEF_W'(1) << FRAC_BITS;
    localparam logic signed [SUM_W-1:0]  SUM_RND  = SUM_W'(1) << (FRAC_BITS - 1);

    // q30 to FRAC_BITS, round half up, clamp to [-1, +1]
    function automatic logic signed [COEF_W-1:0] to_coef(
        input logic signed [XY_W-1:0] q
    );
        logic signed [XY_W-1:0] r;
        r = (q + COEF_RND) >>> (30 - FRAC_BITS);
        if (r > ONE_XY) begin
            r = ONE_XY;
        end else if (r < -ONE_XY) begin
            r = -ONE_XY;
        end
        return COEF_W'(r);
    endfunction

    // round a product sum and clamp to 32 bits
    function automatic logic signed [VEC_W:0] round_sat(
        input logic signed [PROD_W-1:0] p0,
        input logic signed [PROD_W-1:0] p1
    );
        logic signed [SUM_W-1:0] s;
        logic                    ovf;
        logic signed [VEC_W-1:0] v;
        s   = (SUM_W'(p0) + SUM_W'(p1) + SUM_RND) >>> FRAC_BITS;
        ovf = !((&s[SUM_W-1:VEC_W-1]) || !(|s[SUM_W-1:VEC_W-1]));
        if (ovf) begin
            v = s[SUM_W-1] ? VEC_MIN : VEC_MAX;
        end else begin
            v = s[VEC_W-1:0];
        end
        return {ovf, v};
    endfunction

    // coefficient stage
    logic                     c_vld_reg;
    side_t                    c_side_reg;
    logic signed [VEC_W-1:0]  opa_reg;
    logic signed [VEC_W-1:0]  opb_reg;
    logic signed [COEF_W-1:0] coef_reg [4];
    logic signed [VEC_W-1:0]  opa_next;
    logic signed [VEC_W-1:0]  opb_next;
    logic signed [COEF_W-1:0] coef_next [4];
    logic signed [COEF_W-1:0] cos_c;
    logic signed [COEF_W-1:0] sin_c;

    // product stage
    logic                     p_vld_reg;
    side_t                    p_side_reg;
    logic signed [PROD_W-1:0] prod_reg [4];

    // sum stage
    logic                     s_vld_reg;
    logic signed [VEC_W-1:0]  s_x_reg;
    logic signed [VEC_W-1:0]  s_y_reg;
    logic signed [VEC_W-1:0]  s_z_reg;
    logic                     s_sat_reg;
    logic signed [VEC_W-1:0]  s_x_next;
    logic signed [VEC_W-1:0]  s_y_next;
    logic signed [VEC_W-1:0]  s_z_next;
    logic                     s_sat_next;
    logic signed [VEC_W:0]    sum_p;
    logic signed [VEC_W:0]    sum_q;

    // pick operand pair and signed coefficients for the axis
    always_comb begin
        cos_c = in_neg ? -to_coef(in_cos) : to_coef(in_cos);
        sin_c = in_neg ? -to_coef(in_sin) : to_coef(in_sin);
        unique case (in_side.axis) inside
            AXIS_X: begin
                opa_next     = in_side.vy;
                opb_next     = in_side.vz;
                coef_next[0] = cos_c;
                coef_next[1] = -sin_c;
                coef_next[2] = sin_c;
                coef_next[3] = cos_c;
            end
            AXIS_Y: begin
                opa_next     = in_side.vx;
                opb_next     = in_side.vz;
                coef_next[0] = cos_c;
                coef_next[1] = sin_c;
                coef_next[2] = -sin_c;
                coef_next[3] = cos_c;
            end
            AXIS_Z, AXIS_NONE: begin
                opa_next     = in_side.vx;
                opb_next     = in_side.vy;
                coef_next[0] = cos_c;
                coef_next[1] = -sin_c;
                coef_next[2] = sin_c;
                coef_next[3] = cos_c;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            c_vld_reg <= 1'b0;
            p_vld_reg <= 1'b0;
            s_vld_reg <= 1'b0;
        end else if (adv) begin
            c_vld_reg <= in_vld;
            p_vld_reg <= c_vld_reg;
            s_vld_reg <= p_vld_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (adv) begin
            c_side_reg <= in_side;
            opa_reg    <= opa_next;
            opb_reg    <= opb_next;
            for (int k = 0; k < 4; k++) begin
                coef_reg[k] <= coef_next[k];
            end
        end
    end

    // four parallel multiplies
    always_ff @(posedge aclk) begin
        if (adv) begin
            p_side_reg  <= c_side_reg;
            prod_reg[0] <= PROD_W'(opa_reg) * PROD_W'(coef_reg[0]);
            prod_reg[1] <= PROD_W'(opb_reg) * PROD_W'(coef_reg[1]);
            prod_reg[2] <= PROD_W'(opa_reg) * PROD_W'(coef_reg[2]);
            prod_reg[3] <= PROD_W'(opb_reg) * PROD_W'(coef_reg[3]);
        end
    end

    // round, saturate and place the rotated pair
    always_comb begin
        sum_p      = round_sat(prod_reg[0], prod_reg[1]);
        sum_q      = round_sat(prod_reg[2], prod_reg[3]);
        s_x_next   = p_side_reg.vx;
        s_y_next   = p_side_reg.vy;
        s_z_next   = p_side_reg.vz;
        s_sat_next = sum_p[VEC_W] | sum_q[VEC_W];
        unique case (p_side_reg.axis)
            AXIS_X: begin
                s_y_next = sum_p[VEC_W-1:0];
                s_z_next = sum_q[VEC_W-1:0];
            end
            AXIS_Y: begin
                s_x_next = sum_p[VEC_W-1:0];
                s_z_next = sum_q[VEC_W-1:0];
            end
            AXIS_Z: begin
                s_x_next = sum_p[VEC_W-1:0];
                s_y_next = sum_q[VEC_W-1:0];
            end
            AXIS_NONE: begin
                s_sat_next = 1'b0;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (adv) begin
            s_x_reg   <= s_x_next;
            s_y_reg   <= s_y_next;
            s_z_reg   <= s_z_next;
            s_sat_reg <= s_sat_next;
        end
    end

    assign out_vld = s_vld_reg;
    assign out_x   = s_x_reg;
    assign out_y   = s_y_reg;
    assign out_z   = s_z_reg;
    assign out_sat = s_sat_reg;

    // rounded coefficients never leave [-1, +1]
    a_coef_range: assert property (@(posedge aclk) disable iff (!aresetn)
        c_vld_reg |-> (coef_reg[0] <= ONE_COEF && coef_reg[0] >= -ONE_COEF &&
                       coef_reg[2] <= ONE_COEF && coef_reg[2] >= -ONE_COEF))
        else $error("cos/sin coefficient out of range");

    // cosine sits on the diagonal of the rotation
    a_coef_diag: assert property (@(posedge aclk) disable iff (!aresetn)
        c_vld_reg |-> (coef_reg[0] == coef_reg[3] && coef_reg[1] == -coef_reg[2]))
        else $error("rotation coefficients are inconsistent");

endmodule

@@ tb/vector_axis_rotation_top_tb.sv @@
`timescale 1ns / 1ps
// self-checking testbench for vector_axis_rotation_top: directed table, then random requests
// depends on vecrot_pkg and the rtl of the block; rotations predicted by a local cordic model
module vector_axis_rotation_top_tb;
    import vecrot_pkg::*;

    // predictor setup, follows the package configuration
    localparam int     N_ITER    = CORDIC_STAGES;
    localparam int     FRAC      = FRAC_BITS;
    localparam longint ANG_PI    = 64'sd843314857;
    localparam longint ANG_HPI   = 64'sd421657428;
    localparam longint ANG_2PI   = 64'sd1686629713;
    localparam longint GAIN_INF  = 64'sd652032874;
    localparam longint GAIN_INIT = (N_ITER < 16) ?
        GAIN_INF + (((GAIN_INF * 2) / 3) >>> (2 * N_ITER)) : GAIN_INF;

    // run shape
    localparam int N_RANDOM    = 1526;
    localparam int HOLD_CYCLES = 250;
    localparam int DRAIN_WAIT  = 2 + CORDIC_STAGES + 3 + 12;
    localparam int TIMEOUT_NS  = 4_000_000;

    // directed angles, q3.28 in the 31-bit field
    localparam logic signed [30:0] A_PI  = 31'sd843314857;
    localparam logic signed [30:0] A_HPI = 31'sd421657428;
    localparam logic signed [30:0] A_QPI = 31'sd210828714;
    localparam logic signed [30:0] A_TOP = 31'sh3fffffff;
    localparam logic signed [30:0] A_BOT = 31'sh40000000;

    // small directed vector: 1.5, -2.25, 3.0
    localparam logic signed [31:0] P1 = 32'sh00018000;
    localparam logic signed [31:0] P2 = 32'shfffdc000;
    localparam logic signed [31:0] P3 = 32'sh00030000;

    typedef struct packed {
        axis_t                 axis;
        logic signed [31:0]    vx;
        logic signed [31:0]    vy;
        logic signed [31:0]    vz;
        logic signed [30:0]    angle;
    } rot_req_t;

    typedef struct packed {
        logic signed [31:0]    ox;
        logic signed [31:0]    oy;
        logic signed [31:0]    oz;
        logic                  sat;
    } rot_res_t;

    typedef struct packed {
        logic                  typed;
        rot_req_t              req;
        rot_res_t              want;
    } row_t;

    localparam rot_res_t NO_RES   = '0;
    localparam rot_res_t ZERO_RES = '0;
    localparam int       DIR_ROWS = 24;

    // directed table; typed expectations only where obvious
    row_t dir_tab [DIR_ROWS] = '{
        // axis code 3 passes through, extremes of the x, y and angle fields
        '{1'b1, '{AXIS_NONE, VEC_MAX, VEC_MIN, 32'sh12345678, A_TOP},
                '{VEC_MAX, VEC_MIN, 32'sh12345678, 1'b0}},
        '{1'b1, '{AXIS_NONE, VEC_MIN, VEC_MAX, 32'shffffffff, A_BOT},
                '{VEC_MIN, VEC_MAX, 32'shffffffff, 1'b0}},
        // zero vector stays zero for any angle
        '{1'b1, '{AXIS_X, 32'sd0, 32'sd0, 32'sd0, A_PI}, ZERO_RES},
        '{1'b1, '{AXIS_Z, 32'sd0, 32'sd0, 32'sd0, A_BOT}, ZERO_RES},
        '{1'b1, '{AXIS_Y, 32'sd0, 32'sd0, 32'sd0, A_TOP}, ZERO_RES},
        // each axis at zero angle
        '{1'b0, '{AXIS_X, P1, P2, P3, 31'sd0}, NO_RES},
        '{1'b0, '{AXIS_Y, P1, P2, P3, 31'sd0}, NO_RES},
        '{1'b0, '{AXIS_Z, P1, P2, P3, 31'sd0}, NO_RES},
        // quarter turn edges and just past them
        '{1'b0, '{AXIS_X, P1, P2, P3, A_HPI}, NO_RES},
        '{1'b0, '{AXIS_Y, P1, P2, P3, -A_HPI}, NO_RES},
        '{1'b0, '{AXIS_Z, P1, P2, P3, A_HPI + 31'sd1}, NO_RES},
        '{1'b0, '{AXIS_X, P1, P2, P3, -A_HPI - 31'sd1}, NO_RES},
        // half turn edges and wrap past pi
        '{1'b0, '{AXIS_Y, P1, P2, P3, A_PI}, NO_RES},
        '{1'b0, '{AXIS_Z, P1, P2, P3, -A_PI}, NO_RES},
        '{1'b0, '{AXIS_X, P1, P2, P3, A_PI + 31'sd1}, NO_RES},
        '{1'b0, '{AXIS_Y, P1, P2, P3, -A_PI - 31'sd1}, NO_RES},
        '{1'b0, '{AXIS_Z, P1, P2, P3, A_TOP}, NO_RES},
        '{1'b0, '{AXIS_X, P1, P2, P3, A_BOT}, NO_RES},
        // saturating rotations
        '{1'b0, '{AXIS_Z, VEC_MAX, VEC_MAX, 32'sd0, A_QPI}, NO_RES},
        '{1'b0, '{AXIS_X, 32'sd0, VEC_MIN, VEC_MIN, -A_QPI}, NO_RES},
        '{1'b0, '{AXIS_Y, VEC_MIN, VEC_MIN, VEC_MIN, A_HPI}, NO_RES},
        '{1'b0, '{AXIS_Y, VEC_MIN, 32'sd0, VEC_MAX, A_PI}, NO_RES},
        // tiny angles and rounding of small negatives
        '{1'b0, '{AXIS_X, -32'sd1, -32'sd1, -32'sd1, 31'sd1}, NO_RES},
        '{1'b0, '{AXIS_Z, 32'sh7fff0000, 32'sh80010000, P3, -31'sd1}, NO_RES}
    };

    longint atan_tab [32] = '{
        210828714, 124459457, 65760959, 33381290, 16755422, 8385879,
        4193963, 2097109, 1048571, 524287, 262144, 131072, 65536, 32768,
        16384, 8192, 4096, 2048, 1024, 512, 256, 128, 64, 32, 16, 8, 4, 2,
        1, 0, 0, 0
    };

    logic                  aclk;
    logic                  aresetn;
    logic                  s_tvalid;
    logic                  s_tready;
    logic [S_DATA_W-1:0]   s_tdata;
    logic [1:0]            s_tuser;
    logic                  m_tvalid;
    logic                  m_tready;
    logic [M_DATA_W-1:0]   m_tdata;
    logic                  m_tuser;

    rot_res_t rotated_q [$];
    int n_accepted;
    int n_checked;
    int n_errors;
    int n_stall;
    int n_clamped;
    int holds_done;
    int tx_burst;
    int rx_burst;

    vector_axis_rotation_top DUT (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser)
    );

    // clock
    initial aclk = 1'b0;
    always #2 aclk = ~aclk;

    // q30 cordic output to a clamped coefficient with FRAC fraction bits
    function automatic longint round_coef(input longint q30);
        longint one;
        longint r;
        one = 64'sd1 <<< FRAC;
        r = (q30 + (64'sd1 <<< (29 - FRAC))) >>> (30 - FRAC);
        if (r > one) r = one;
        if (r < -one) r = -one;
        return r;
    endfunction

    // sine and cosine of a q3.28 angle, with range folding
    function automatic void cordic_sincos(input longint ang, output longint c,
                                          output longint s);
        longint cx;
        longint cy;
        longint cz;
        longint nx;
        bit flip;
        flip = 1'b0;
        if (ang > ANG_PI) ang -= ANG_2PI;
        if (ang < -ANG_PI) ang += ANG_2PI;
        if (ang > ANG_HPI) begin
            ang -= ANG_PI;
            flip = 1'b1;
        end else if (ang < -ANG_HPI) begin
            ang += ANG_PI;
            flip = 1'b1;
        end
        cx = GAIN_INIT;
        cy = 0;
        cz = ang;
        for (int i = 0; i < N_ITER && i < 32; i++) begin
            if (cz >= 0) begin
                nx = cx - (cy >>> i);
                cy = cy + (cx >>> i);
                cz -= atan_tab[i];
            end else begin
                nx = cx + (cy >>> i);
                cy = cy - (cx >>> i);
                cz += atan_tab[i];
            end
            cx = nx;
        end
        c = round_coef(cx);
        s = round_coef(cy);
        if (flip) begin
            c = -c;
            s = -s;
        end
    endfunction

    // a * ca + b * cb, rounded to q16.16 and clamped to 32 bits
    function automatic logic [31:0] rot_term(input longint a, input longint b,
                                             input longint ca, input longint cb,
                                             inout bit sat);
        longint sum;
        sum = a * ca + b * cb;
        sum = (sum + (64'sd1 <<< (FRAC - 1))) >>> FRAC;
        if (sum > 64'sd2147483647) begin
            sat = 1'b1;
            return VEC_MAX;
        end
        if (sum < -64'sd2147483648) begin
            sat = 1'b1;
            return VEC_MIN;
        end
        return sum[31:0];
    endfunction

    // expected rotated vector for one request
    function automatic rot_res_t rotate_about_axis(input rot_req_t r);
        longint x;
        longint y;
        longint z;
        longint c;
        longint s;
        bit sat;
        rot_res_t o;
        x = r.vx;
        y = r.vy;
        z = r.vz;
        sat = 1'b0;
        o.ox = r.vx;
        o.oy = r.vy;
        o.oz = r.vz;
        if (r.axis != AXIS_NONE) begin
            cordic_sincos(r.angle, c, s);
            case (r.axis)
                AXIS_X: begin
                    o.oy = rot_term(y, z, c, -s, sat);
                    o.oz = rot_term(y, z, s, c, sat);
                end
                AXIS_Y: begin
                    o.ox = rot_term(x, z, c, s, sat);
                    o.oz = rot_term(x, z, -s, c, sat);
                end
                default: begin
                    o.ox = rot_term(x, y, c, -s, sat);
                    o.oy = rot_term(x, y, s, c, sat);
                end
            endcase
        end
        o.sat = sat;
        return o;
    endfunction

    // idle length: mostly none or short, a few long, sometimes a run of none
    function automatic int pick_gap(inout int burst);
        int r;
        if (burst > 0) begin
            burst--;
            return 0;
        end
        r = $urandom_range(0, 99);
        if (r < 4) begin
            burst = $urandom_range(20, 80);
            return 0;
        end
        if (r < 55) return 0;
        if (r < 85) return $urandom_range(1, 3);
        if (r < 97) return $urandom_range(4, 12);
        return $urandom_range(20, 60);
    endfunction

    // vector component: extremes, small values around zero, or anything
    function automatic logic [31:0] pick_comp();
        case ($urandom_range(0, 9))
            0:       return VEC_MAX;
            1:       return VEC_MIN;
            2, 3, 4: return $urandom_range(0, 32'h001f_ffff) - 32'h0010_0000;
            default: return $urandom;
        endcase
    endfunction

    // angle: mostly within +-pi, some near the folding edges, some full field
    function automatic logic [30:0] pick_angle();
        int b;
        case ($urandom_range(0, 9))
            0: return 31'($urandom);
            1, 2: begin
                case ($urandom_range(0, 4))
                    0:       b = int'(A_PI);
                    1:       b = -int'(A_PI);
                    2:       b = int'(A_HPI);
                    3:       b = -int'(A_HPI);
                    default: b = 0;
                endcase
                b = b + int'($urandom_range(0, 8)) - 4;
                return b[30:0];
            end
            default: begin
                b = int'($urandom_range(0, 32'd1686629714)) - int'(A_PI);
                return b[30:0];
            end
        endcase
    endfunction

    function automatic rot_req_t pick_req();
        rot_req_t r;
        if ($urandom_range(0, 9) == 0) r.axis = AXIS_NONE;
        else r.axis = axis_t'($urandom_range(0, 2));
        r.vx = pick_comp();
        r.vy = pick_comp();
        r.vz = pick_comp();
        r.angle = pick_angle();
        return r;
    endfunction

    // offer one request after a random gap, record its expectation on acceptance
    task automatic send_req(input rot_req_t r, input rot_res_t want);
        int gap;
        gap = pick_gap(tx_burst);
        if (gap > 0) begin
            s_tvalid = 1'b0;
            s_tdata  = {$urandom, $urandom, $urandom, $urandom};
            s_tuser  = 2'($urandom);
            repeat (gap) @(negedge aclk);
        end
        s_tvalid = 1'b1;
        s_tdata  = {1'b0, r.angle, r.vz, r.vy, r.vx};
        s_tuser  = r.axis;
        @(posedge aclk);
        while (!s_tready) @(posedge aclk);
        rotated_q.push_back(want);
        n_accepted++;
        @(negedge aclk);
    endtask

    task automatic note_error(input string msg);
        n_errors++;
        if (n_errors <= 10) $display("ERROR @%0t: %s", $realtime, msg);
    endtask

    // compare one result against the oldest expectation
    task automatic check_result(input rot_res_t got);
        rot_res_t want;
        if (rotated_q.size() == 0) begin
            note_error($sformatf("unexpected result x=%h y=%h z=%h sat=%b",
                                 got.ox, got.oy, got.oz, got.sat));
            return;
        end
        want = rotated_q.pop_front();
        n_checked++;
        if (got.sat) n_clamped++;
        if (got.ox !== want.ox || got.oy !== want.oy || got.oz !== want.oz ||
            got.sat !== want.sat) begin
            note_error($sformatf(
                "result %0d exp x=%h y=%h z=%h sat=%b got x=%h y=%h z=%h sat=%b",
                n_checked, want.ox, want.oy, want.oz, want.sat,
                got.ox, got.oy, got.oz, got.sat));
        end
    endtask

    // output monitor and input stall count
    always @(posedge aclk) begin
        if (aresetn) begin
            if (s_tvalid && !s_tready) n_stall++;
            if (m_tvalid && m_tready)
                check_result('{m_tdata[31:0], m_tdata[63:32], m_tdata[95:64], m_tuser});
        end
    end

    // result receiver with random stalls and two long hold-offs
    initial begin
        int gap;
        m_tready = 1'b0;
        @(posedge aresetn);
        forever begin
            @(negedge aclk);
            if ((holds_done == 0 && n_accepted >= 400) ||
                (holds_done == 1 && n_accepted >= 1000)) begin
                m_tready = 1'b0;
                holds_done++;
                for (int n = 0; n < HOLD_CYCLES; n++) @(negedge aclk);
            end
            gap = pick_gap(rx_burst);
            if (gap > 0) begin
                m_tready = 1'b0;
                repeat (gap) @(negedge aclk);
            end
            m_tready = 1'b1;
        end
    end

    // reset, stimulus and end of run
    initial begin
        rot_res_t want;
        n_accepted = 0;
        n_checked  = 0;
        n_errors   = 0;
        n_stall    = 0;
        n_clamped  = 0;
        holds_done = 0;
        tx_burst   = 0;
        rx_burst   = 0;
        aresetn    = 1'b0;
        s_tvalid   = 1'b0;
        s_tdata    = '0;
        s_tuser    = '0;
        repeat (5) @(posedge aclk);
        @(negedge aclk);
        aresetn = 1'b1;
        @(negedge aclk);

        // directed table
        for (int i = 0; i < DIR_ROWS; i++) begin
            want = dir_tab[i].typed ? dir_tab[i].want : rotate_about_axis(dir_tab[i].req);
            send_req(dir_tab[i].req, want);
        end

        // random requests
        for (int i = 0; i < N_RANDOM; i++) begin
            rot_req_t r;
            r = pick_req();
            send_req(r, rotate_about_axis(r));
        end
        s_tvalid = 1'b0;

        // drain, then give stray results time to show up
        while (rotated_q.size() != 0) @(posedge aclk);
        repeat (DRAIN_WAIT) @(posedge aclk);

        $display("rotated %0d vectors (%0d clamped) from %0d requests, %0d mismatches",
                 n_checked, n_clamped, n_accepted, n_errors);
        $display("input stalled %0d cycles under output backpressure, %0d long hold-offs",
                 n_stall, holds_done);
        if (n_errors == 0) begin
            $display("SCOREBOARD CLEAN");
        end else begin
            $display("SCOREBOARD MISMATCH");
        end
        $finish;
    end

    // watchdog
    initial begin
        #(TIMEOUT_NS);
        $display("timeout with %0d results outstanding", rotated_q.size());
        $display("SCOREBOARD MISMATCH");
        $finish;
    end

endmodule
